FILE: hdl/l1_coherence_line_controller_assert.svh
// Assertion macros shared by the coherence line controller modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef L1_COHERENCE_LINE_CONTROLLER_ASSERT_SVH
`define L1_COHERENCE_LINE_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define L1CLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define L1CLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/l1clc_pkg.sv
package l1clc_pkg;

	// Table geometry
	localparam int LINES  = 64;
	localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;

	// Per-line coherence state
	typedef enum logic [3:0] {
		LS_I  = 4'd0,
		LS_IS = 4'd1,
		LS_IE = 4'd2,
		LS_S  = 4'd3,
		LS_SI = 4'd4,
		LS_SE = 4'd5,
		LS_E  = 4'd6,
		LS_EI = 4'd7,
		LS_M  = 4'd8,
		LS_MI = 4'd9
	} line_state_t;

	// Request kinds (travel on s_tuser)
	typedef enum logic [2:0] {
		KIND_LOAD  = 3'd0,
		KIND_STORE = 3'd1,
		KIND_L2RSP = 3'd2,
		KIND_EVICT = 3'd3,
		KIND_SSI   = 3'd4
	} kind_t;

	// Commands toward L2
	typedef enum logic [1:0] {
		L2_NONE = 2'd0,
		L2_GETS = 2'd1,
		L2_GETE = 2'd2,
		L2_PUT  = 2'd3
	} l2_cmd_t;

	// Cache events
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_RDHIT  = 3'd1,
		EV_WRHIT  = 3'd2,
		EV_INS_SH = 3'd3,
		EV_INS_WR = 3'd4,
		EV_INVAL  = 3'd5
	} cache_event_t;

	// Input payload, first member is the top of s_tdata
	typedef struct packed {
		logic [7:0] transaction_id;
		logic       keep_shared;
		logic       granted_shared;
		logic [5:0] line_index;
	} in_item_t;

	// Result payload, first member is the top of m_tdata
	typedef struct packed {
		line_state_t  new_state;
		logic         no_action;
		logic         replay_request;
		logic         set_l2_modified;
		logic         txn_close;
		logic         txn_open;
		logic         remove_line;
		cache_event_t cache_event;
		logic         cpu_response;
		l2_cmd_t      l2_command;
		logic [7:0]   result_transaction;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;  // take the request and start the table read
		logic exec;     // update the line and load the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free; // result register can take a new result this cycle
	} dp_status_t;

endpackage

FILE: hdl/l1_coherence_line_controller.sv
// Channel  Handshake                 Payload
// s        s_tvalid / s_tready       s_tdata[15:0], s_tuser[2:0] (kind)
// m        m_tvalid / m_tready       m_tdata[23:0]
// cfg      cfg_valid / cfg_ready     cfg_data (blocking_cache)
//
// Each request goes through a registered line-table read, then the transition and
// write-back into the table; the next request is taken after.
// A stalled result holds the controller in its write-back cycle until m_tready.
// Reset (arst_n low) clears all line valid bits, so every line reads I, and sets
// blocking_cache to 1. cfg_ready is always high.
module l1_coherence_line_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // line_index[5:0], granted_shared, keep_shared, transaction_id[7:0]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // result_transaction[7:0], l2_command[1:0], cpu_response,
	                              // cache_event[2:0], remove_line, txn_open,
	                              // txn_close, set_l2_modified, replay_request,
	                              // no_action, new_state[3:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	l1clc_pkg::dp_cmd_t    cmd;
	l1clc_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	l1clc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	l1clc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: hdl/l1clc_ctrl.sv
`include "l1_coherence_line_controller_assert.svh"

module l1clc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  l1clc_pkg::dp_status_t status,
	output l1clc_pkg::dp_cmd_t   cmd
);

	typedef enum logic [1:0] {
		CS_IDLE = 2'b01,
		CS_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	// Sequencer: read the line, then write it back with the result
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		s_tready    = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.exec = status.out_free;
				if (status.out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`L1CLC_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_q == CS_EXEC, "capture did not move to exec")
	`L1CLC_ASSERT_NOW(a_no_overlap, cmd.capture || cmd.exec, !(cmd.capture && cmd.exec), "capture and exec overlap")
	`L1CLC_ASSERT_NEXT(a_stall_holds, (state_q == CS_EXEC) && !status.out_free, !s_tready, "request taken while a result stalls")

endmodule

FILE: hdl/l1clc_datapath.sv
`include "l1_coherence_line_controller_assert.svh"

module l1clc_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  l1clc_pkg::dp_cmd_t    cmd,
	output l1clc_pkg::dp_status_t status,
	input  logic [15:0]           s_tdata,
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_data
);

	l1clc_pkg::line_state_t line_mem_q [l1clc_pkg::LINES];
	logic [l1clc_pkg::LINES-1:0] line_vld_q;

	l1clc_pkg::in_item_t    item_s1;
	logic [2:0]             kind_s1;
	l1clc_pkg::line_state_t rd_state_s1;
	logic                   rd_vld_s1;

	logic                   blocking_q;
	logic                   m_tvalid_q;
	l1clc_pkg::out_item_t   out_q;
	l1clc_pkg::out_item_t   res;

	logic [l1clc_pkg::LINE_W-1:0] rd_addr;
	logic [l1clc_pkg::LINE_W-1:0] wr_addr;
	logic                         in_range;
	l1clc_pkg::line_state_t       cur;
	logic                         is_store;

	assign rd_addr  = s_tdata[l1clc_pkg::LINE_W-1:0];
	assign wr_addr  = item_s1.line_index[l1clc_pkg::LINE_W-1:0];
	assign in_range = (32'(item_s1.line_index) < l1clc_pkg::LINES);
	assign cur      = rd_vld_s1 ? rd_state_s1 : l1clc_pkg::LS_I;
	assign is_store = (kind_s1 == l1clc_pkg::KIND_STORE);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocking_q <= 1'b1;
		end else if (cfg_valid) begin
			blocking_q <= cfg_data;
		end
	end

	// Request capture and registered table read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_s1     <= l1clc_pkg::in_item_t'(s_tdata);
			kind_s1     <= s_tuser;
			rd_state_s1 <= line_mem_q[rd_addr];
			rd_vld_s1   <= line_vld_q[rd_addr];
		end
	end

	// Table write-back
	always_ff @(posedge clk) begin
		if (cmd.exec && in_range) begin
			line_mem_q[wr_addr] <= res.new_state;
		end
	end

	// Per-line valid bits, an unwritten line reads as I
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q <= '0;
		end else if (cmd.exec && in_range) begin
			line_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Coherence transition rules
	always_comb begin
		res                    = '0;
		res.result_transaction = item_s1.transaction_id;
		res.l2_command         = l1clc_pkg::L2_NONE;
		res.cache_event        = l1clc_pkg::EV_NONE;
		res.new_state          = l1clc_pkg::LS_I;
		if (!in_range) begin
			res.no_action = 1'b1;
		end else begin
			res.new_state = cur;
			unique case (kind_s1)
				l1clc_pkg::KIND_LOAD, l1clc_pkg::KIND_STORE: begin
					unique case (cur)
						l1clc_pkg::LS_I: begin
							res.new_state      = is_store ? l1clc_pkg::LS_IE : l1clc_pkg::LS_IS;
							res.l2_command     = is_store ? l1clc_pkg::L2_GETE : l1clc_pkg::L2_GETS;
							res.txn_open       = 1'b1;
							res.replay_request = !blocking_q;
						end
						l1clc_pkg::LS_S: begin
							if (is_store) begin
								res.l2_command = l1clc_pkg::L2_GETE;
								res.txn_open   = 1'b1;
								res.new_state  = l1clc_pkg::LS_SE;
							end else begin
								res.cpu_response = 1'b1;
								res.cache_event  = l1clc_pkg::EV_RDHIT;
							end
						end
						l1clc_pkg::LS_E: begin
							res.cpu_response = 1'b1;
							if (is_store) begin
								res.new_state       = l1clc_pkg::LS_M;
								res.set_l2_modified = 1'b1;
								res.cache_event     = l1clc_pkg::EV_WRHIT;
							end else begin
								res.cache_event = l1clc_pkg::EV_RDHIT;
							end
						end
						l1clc_pkg::LS_M: begin
							res.cpu_response = 1'b1;
							res.cache_event  = is_store ? l1clc_pkg::EV_WRHIT : l1clc_pkg::EV_RDHIT;
						end
						default: begin
							res.no_action = 1'b1;
						end
					endcase
				end
				l1clc_pkg::KIND_L2RSP: begin
					unique case (cur)
						l1clc_pkg::LS_IS: begin
							res.new_state   = item_s1.granted_shared ? l1clc_pkg::LS_S
							                                         : l1clc_pkg::LS_E;
							res.cache_event = item_s1.granted_shared ? l1clc_pkg::EV_INS_SH
							                                         : l1clc_pkg::EV_INS_WR;
							res.txn_close   = 1'b1;
						end
						l1clc_pkg::LS_IE, l1clc_pkg::LS_SE: begin
							res.new_state   = l1clc_pkg::LS_E;
							res.cache_event = l1clc_pkg::EV_INS_WR;
							res.txn_close   = 1'b1;
						end
						l1clc_pkg::LS_SI, l1clc_pkg::LS_EI, l1clc_pkg::LS_MI: begin
							res.new_state   = l1clc_pkg::LS_I;
							res.remove_line = 1'b1;
							res.txn_close   = 1'b1;
							res.cache_event = l1clc_pkg::EV_INVAL;
						end
						default: begin
							res.no_action = 1'b1;
						end
					endcase
				end
				l1clc_pkg::KIND_EVICT: begin
					if (cur == l1clc_pkg::LS_M || cur == l1clc_pkg::LS_E) begin
						res.l2_command = l1clc_pkg::L2_PUT;
						res.new_state  = (cur == l1clc_pkg::LS_M) ? l1clc_pkg::LS_MI
						                                          : l1clc_pkg::LS_EI;
						res.txn_open   = 1'b1;
					end else begin
						res.no_action = 1'b1;
					end
				end
				l1clc_pkg::KIND_SSI: begin
					res.new_state   = item_s1.keep_shared ? l1clc_pkg::LS_S : l1clc_pkg::LS_I;
					res.remove_line = !item_s1.keep_shared;
				end
				default: begin
					res.no_action = 1'b1;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.exec) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q <= res;
		end
	end

	assign status.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = out_q;

	`L1CLC_ASSERT_NOW(a_start_end_excl, m_tvalid_q, !(out_q.txn_open && out_q.txn_close), "open and close together")
	`L1CLC_ASSERT_NOW(a_replay_miss, m_tvalid_q && out_q.replay_request, out_q.l2_command == l1clc_pkg::L2_GETS || out_q.l2_command == l1clc_pkg::L2_GETE, "replay without miss command")
	`L1CLC_ASSERT_NEXT(a_line_written, cmd.exec && in_range, line_vld_q[$past(wr_addr)], "line not marked written")
	`L1CLC_ASSERT_NOW(a_exec_free, cmd.exec, !m_tvalid_q || m_tready, "result overwritten while stalled")

endmodule
